>>> rtl/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants of the websocket frame deframer: parser phase
// codes, frame opcodes, length escapes and result event kinds.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // Parser phase codes
  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_MASK = 3'd3;
  localparam logic [2:0] PH_PAY  = 3'd4;

  // Frame opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  // Seven-bit length escapes and the byte counts they announce
  localparam logic [6:0] LEN_ESC16  = 7'd126;
  localparam logic [6:0] LEN_ESC64  = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_BYTES  = 4'd4;

  // Close code bytes collected before saturation
  localparam logic [1:0] CLOSE_CODE_BYTES = 2'd2;

  // Event kinds
  localparam logic [2:0] EV_TEXT_BYTE   = 3'd0;
  localparam logic [2:0] EV_TEXT_END    = 3'd1;
  localparam logic [2:0] EV_BINARY_REJ  = 3'd2;
  localparam logic [2:0] EV_MASKED_REJ  = 3'd3;
  localparam logic [2:0] EV_CLOSE       = 3'd4;
  localparam logic [2:0] EV_SEND_PONG   = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic        has_byte;
    logic        eom;
    logic [15:0] code;
  } result_t;

endpackage

>>> rtl/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Receive-side websocket frame parser. Takes one received byte per
// transaction and gives at most one event per byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: rx_byte_i with in_valid_i / in_stall_o. A transaction
//   happens on a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: event_kind_o, data_byte_o, has_byte_o, end_of_message_o,
//   close_code_o with out_valid_o / out_stall_i, same rule.
//   Each byte updates the header/payload parser in the cycle it is taken;
//   the event it causes (if any) goes to the output register, or to the skid
//   register while the receiver stalls. Throughput is one byte per cycle while
//   in_stall_o is low; the parser is a single registered step per byte, with
//   the 64-bit remaining length decrement and zero test as its longest path.
//   When the receiver stalls, the output register holds its event and one
//   more event goes to a skid register; in_stall_o rises only while the
//   skid register is full, so at most two events are buffered.
//   Reset (rst_ni low, asynchronous) returns the parser to the first header
//   byte, clears held opcode and length state and empties both registers.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_kind_o,
  output logic [7:0]  data_byte_o,
  output logic        has_byte_o,
  output logic        end_of_message_o,
  output logic [15:0] close_code_o
);

  logic [2:0]  phase_q, phase_d;
  logic        final_q, final_d;
  logic [3:0]  op_q, op_d;
  logic [3:0]  held_q, held_d;
  logic        masked_q, masked_d;
  logic [3:0]  hbc_q, hbc_d;
  logic [63:0] rem_q, rem_d;
  logic [15:0] cc_q, cc_d;
  logic [1:0]  pidx_q, pidx_d;

  wsfd_pkg::result_t ev, out_q, skid_q;
  logic ev_valid;
  logic out_valid_q, skid_valid_q;
  logic in_acc;
  logic out_free;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    logic do_after;
    logic do_finish;
    logic do_end;
    logic last;
    logic [3:0] eff;

    phase_d   = phase_q;
    final_d   = final_q;
    op_d      = op_q;
    held_d    = held_q;
    masked_d  = masked_q;
    hbc_d     = hbc_q;
    rem_d     = rem_q;
    cc_d      = cc_q;
    pidx_d    = pidx_q;
    ev        = '0;
    ev_valid  = 1'b0;
    do_after  = 1'b0;
    do_finish = 1'b0;
    do_end    = 1'b0;
    last      = (rem_q[63:1] == 63'd0);
    eff       = op_q;

    if (in_acc) begin
      case (phase_q)
        wsfd_pkg::PH_HDR1: begin
          masked_d = rx_byte_i[7];
          rem_d    = '0;
          if (rx_byte_i[6:0] == wsfd_pkg::LEN_ESC16) begin
            hbc_d   = wsfd_pkg::EXT16_BYTES;
            phase_d = wsfd_pkg::PH_EXT;
          end else if (rx_byte_i[6:0] == wsfd_pkg::LEN_ESC64) begin
            hbc_d   = wsfd_pkg::EXT64_BYTES;
            phase_d = wsfd_pkg::PH_EXT;
          end else begin
            rem_d    = {57'd0, rx_byte_i[6:0]};
            do_after = 1'b1;
          end
        end
        wsfd_pkg::PH_EXT: begin
          rem_d = {rem_q[55:0], rx_byte_i};
          hbc_d = hbc_q - 4'd1;
          if (hbc_q == 4'd1) do_after = 1'b1;
        end
        wsfd_pkg::PH_MASK: begin
          hbc_d = hbc_q - 4'd1;
          if (hbc_q == 4'd1) do_finish = 1'b1;
        end
        wsfd_pkg::PH_PAY: begin
          rem_d = rem_q - {63'd0, (rem_q != 64'd0)};
          if (masked_q) begin
            // drop masked payload silently
            if (last) phase_d = wsfd_pkg::PH_HDR0;
          end else if (op_q == wsfd_pkg::OP_TEXT) begin
            if (last) phase_d = wsfd_pkg::PH_HDR0;
            ev_valid    = 1'b1;
            ev.kind     = wsfd_pkg::EV_TEXT_BYTE;
            ev.data     = rx_byte_i;
            ev.has_byte = 1'b1;
            ev.eom      = last && final_q;
          end else begin
            if (op_q == wsfd_pkg::OP_CLOSE && pidx_q < wsfd_pkg::CLOSE_CODE_BYTES) begin
              if (pidx_q == 2'd0) cc_d = {rx_byte_i, 8'd0};
              else                cc_d = cc_q | {8'd0, rx_byte_i};
              pidx_d = pidx_q + 2'd1;
            end
            if (last) do_end = 1'b1;
          end
        end
        default: begin
          final_d = rx_byte_i[7];
          op_d    = rx_byte_i[3:0];
          phase_d = wsfd_pkg::PH_HDR1;
        end
      endcase

      if (do_after) begin
        if (masked_d) begin
          phase_d = wsfd_pkg::PH_MASK;
          hbc_d   = wsfd_pkg::MASK_BYTES;
        end else begin
          do_finish = 1'b1;
        end
      end

      if (do_finish) begin
        if (masked_d) begin
          phase_d  = (rem_d != 64'd0) ? wsfd_pkg::PH_PAY : wsfd_pkg::PH_HDR0;
          ev_valid = 1'b1;
          ev.kind  = wsfd_pkg::EV_MASKED_REJ;
        end else begin
          eff = op_q;
          if (op_q != wsfd_pkg::OP_CONT) begin
            cc_d   = '0;
            pidx_d = '0;
          end
          if (final_q) begin
            // final continuation takes the held opcode and ends the message
            if (op_q == wsfd_pkg::OP_CONT && held_q != wsfd_pkg::OP_CONT) begin
              eff    = held_q;
              held_d = wsfd_pkg::OP_CONT;
            end
          end else begin
            if (held_q == wsfd_pkg::OP_CONT) held_d = op_q;
            else if (op_q == wsfd_pkg::OP_CONT) eff = held_q;
          end
          op_d = eff;
          if (rem_d == 64'd0) do_end = 1'b1;
          else                phase_d = wsfd_pkg::PH_PAY;
        end
      end

      if (do_end) begin
        phase_d = wsfd_pkg::PH_HDR0;
        if (final_q) begin
          case (op_d)
            wsfd_pkg::OP_TEXT: begin
              ev_valid = 1'b1;
              ev.kind  = wsfd_pkg::EV_TEXT_END;
              ev.eom   = 1'b1;
            end
            wsfd_pkg::OP_BINARY: begin
              ev_valid = 1'b1;
              ev.kind  = wsfd_pkg::EV_BINARY_REJ;
              ev.eom   = 1'b1;
            end
            wsfd_pkg::OP_CLOSE: begin
              ev_valid = 1'b1;
              ev.kind  = wsfd_pkg::EV_CLOSE;
              ev.eom   = 1'b1;
              ev.code  = cc_d;
            end
            wsfd_pkg::OP_PING: begin
              ev_valid = 1'b1;
              ev.kind  = wsfd_pkg::EV_SEND_PONG;
              ev.eom   = 1'b1;
            end
            default: ev_valid = 1'b0;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsfd_pkg::PH_HDR0;
      final_q  <= 1'b0;
      op_q     <= wsfd_pkg::OP_CONT;
      held_q   <= wsfd_pkg::OP_CONT;
      masked_q <= 1'b0;
      hbc_q    <= '0;
      rem_q    <= '0;
      cc_q     <= '0;
      pidx_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      final_q  <= final_d;
      op_q     <= op_d;
      held_q   <= held_d;
      masked_q <= masked_d;
      hbc_q    <= hbc_d;
      rem_q    <= rem_d;
      cc_q     <= cc_d;
      pidx_q   <= pidx_d;
    end
  end

  // Output register plus skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= ev_valid;
      end
    end else if (ev_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (ev_valid) out_q <= ev;
    end else if (ev_valid) begin
      skid_q <= ev;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = out_q.kind;
  assign data_byte_o      = out_q.data;
  assign has_byte_o       = out_q.has_byte;
  assign end_of_message_o = out_q.eom;
  assign close_code_o     = out_q.code;

  // Skid register only fills behind a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  // Extended length and mask key phases always have bytes left to take
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == wsfd_pkg::PH_EXT || phase_q == wsfd_pkg::PH_MASK) |-> (hbc_q != 4'd0))
    else $error("header byte count empty in a counted header phase");

  // Masked payload never produces an event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == wsfd_pkg::PH_PAY && masked_q) |-> !ev_valid)
    else $error("event produced from masked payload");

  // A stalled output keeps its event and the skid register catches the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && ev_valid) |=> (skid_valid_q && out_valid_q))
    else $error("event lost while output stalled");

endmodule

>>> tb/websocket_frame_deframer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top_test
// Streams well-formed and broken websocket frames into the deframer. Every
// taken byte runs through a local parser that predicts the event it causes.
// Each event that leaves the block is checked against the oldest prediction.
// Both channels idle at random, and one long receiver hold-off fills the
// block up.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top_test;

  localparam logic [3:0] OP_PONG     = 4'hA;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned OPENING_LEN = 27;
  // Empty text, one-byte text, binary fragment with a ping between its
  // parts, stray continuation, masked text, close with a trailing byte.
  localparam logic [8*OPENING_LEN-1:0] OPENING = {
    8'h81, 8'h00,
    8'h81, 8'h01, 8'hFF,
    8'h02, 8'h01, 8'hAA,
    8'h89, 8'h00,
    8'h80, 8'h00,
    8'h80, 8'h01, 8'h55,
    8'h81, 8'h81, 8'h11, 8'h22, 8'h33, 8'h44, 8'h7E,
    8'h88, 8'h03, 8'h03, 8'hE8, 8'hFF
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  event_kind_o;
  logic [7:0]  data_byte_o;
  logic        has_byte_o;
  logic        end_of_message_o;
  logic [15:0] close_code_o;

  websocket_frame_deframer_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_kind_o     (event_kind_o),
    .data_byte_o      (data_byte_o),
    .has_byte_o       (has_byte_o),
    .end_of_message_o (end_of_message_o),
    .close_code_o     (close_code_o)
  );

  logic [7:0]         rx_stream [$];
  wsfd_pkg::result_t  due_events [$];
  int unsigned bytes_queued = 0;
  int unsigned mismatches = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_ask = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  bit          rx_taken = 1'b0;

  // Parser state, matching the block right after reset
  logic [2:0]  parse_ph = wsfd_pkg::PH_HDR0;
  logic        frame_fin = 1'b0;
  logic [3:0]  frame_op = wsfd_pkg::OP_CONT;
  logic [3:0]  held_op = wsfd_pkg::OP_CONT;
  logic        frame_masked = 1'b0;
  logic [3:0]  hdr_left = 4'd0;
  logic [63:0] len_left = 64'd0;
  logic [15:0] code_acc = 16'd0;
  logic [1:0]  code_taken = 2'd0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  task automatic post_event(input logic [2:0] kind, input logic [7:0] data,
                            input logic has, input logic eom,
                            input logic [15:0] code);
    wsfd_pkg::result_t ev;
    ev.kind = kind;
    ev.data = data;
    ev.has_byte = has;
    ev.eom = eom;
    ev.code = code;
    due_events.push_back(ev);
  endtask

  task automatic close_frame();
    parse_ph = wsfd_pkg::PH_HDR0;
    if (frame_fin) begin
      case (frame_op)
        wsfd_pkg::OP_TEXT:
          post_event(wsfd_pkg::EV_TEXT_END, 8'h00, 1'b0, 1'b1, 16'h0000);
        wsfd_pkg::OP_BINARY:
          post_event(wsfd_pkg::EV_BINARY_REJ, 8'h00, 1'b0, 1'b1, 16'h0000);
        wsfd_pkg::OP_CLOSE:
          post_event(wsfd_pkg::EV_CLOSE, 8'h00, 1'b0, 1'b1, code_acc);
        wsfd_pkg::OP_PING:
          post_event(wsfd_pkg::EV_SEND_PONG, 8'h00, 1'b0, 1'b1, 16'h0000);
        default: ;
      endcase
    end
  endtask

  task automatic settle_header();
    logic [3:0] eff;
    if (frame_masked) begin
      parse_ph = (len_left != 0) ? wsfd_pkg::PH_PAY : wsfd_pkg::PH_HDR0;
      post_event(wsfd_pkg::EV_MASKED_REJ, 8'h00, 1'b0, 1'b0, 16'h0000);
    end else begin
      eff = frame_op;
      if (frame_op != wsfd_pkg::OP_CONT) begin
        code_acc = 16'h0000;
        code_taken = 2'd0;
      end
      // Continuations inherit the opcode held from the first fragment
      if (frame_fin) begin
        if (frame_op == wsfd_pkg::OP_CONT && held_op != wsfd_pkg::OP_CONT) begin
          eff = held_op;
          held_op = wsfd_pkg::OP_CONT;
        end
      end else if (held_op == wsfd_pkg::OP_CONT) begin
        held_op = frame_op;
      end else if (frame_op == wsfd_pkg::OP_CONT) begin
        eff = held_op;
      end
      frame_op = eff;
      if (len_left == 0) close_frame();
      else parse_ph = wsfd_pkg::PH_PAY;
    end
  endtask

  task automatic length_done();
    if (frame_masked) begin
      parse_ph = wsfd_pkg::PH_MASK;
      hdr_left = wsfd_pkg::MASK_BYTES;
    end else begin
      settle_header();
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    case (parse_ph)
      wsfd_pkg::PH_HDR1: begin
        frame_masked = b[7];
        len_left = 64'd0;
        if (b[6:0] == wsfd_pkg::LEN_ESC16) begin
          hdr_left = wsfd_pkg::EXT16_BYTES;
          parse_ph = wsfd_pkg::PH_EXT;
        end else if (b[6:0] == wsfd_pkg::LEN_ESC64) begin
          hdr_left = wsfd_pkg::EXT64_BYTES;
          parse_ph = wsfd_pkg::PH_EXT;
        end else begin
          len_left = {57'd0, b[6:0]};
          length_done();
        end
      end
      wsfd_pkg::PH_EXT: begin
        len_left = {len_left[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) length_done();
      end
      wsfd_pkg::PH_MASK: begin
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) settle_header();
      end
      wsfd_pkg::PH_PAY: begin
        if (len_left != 0) len_left = len_left - 64'd1;
        if (frame_masked) begin
          if (len_left == 0) parse_ph = wsfd_pkg::PH_HDR0;
        end else if (frame_op == wsfd_pkg::OP_TEXT) begin
          if (len_left == 0) parse_ph = wsfd_pkg::PH_HDR0;
          post_event(wsfd_pkg::EV_TEXT_BYTE, b, 1'b1,
                     (len_left == 0) && frame_fin, 16'h0000);
        end else begin
          if (frame_op == wsfd_pkg::OP_CLOSE &&
              code_taken < wsfd_pkg::CLOSE_CODE_BYTES) begin
            if (code_taken == 0) code_acc = {b, 8'h00};
            else code_acc = code_acc | {8'h00, b};
            code_taken = code_taken + 2'd1;
          end
          if (len_left == 0) close_frame();
        end
      end
      default: begin
        frame_fin = b[7];
        frame_op = b[3:0];
        parse_ph = wsfd_pkg::PH_HDR1;
      end
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic push_rx(input logic [7:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endtask

  function automatic int unsigned pick_len();
    return ($urandom_range(19) == 0) ? $urandom_range(300, 126) : $urandom_range(12);
  endfunction

  task automatic queue_frame(input logic fin, input logic [3:0] op, input logic msk,
                             input int unsigned len);
    logic [63:0] len64;
    logic [2:0]  rsv;
    int unsigned enc;
    len64 = 64'(len);
    rsv = 3'($urandom);
    enc = $urandom_range(7);
    push_rx({fin, rsv, op});
    // Mostly the shortest length form, now and then a wider one
    if (len < 126 && enc < 6) begin
      push_rx({msk, len64[6:0]});
    end else if (len < 65536 && enc != 7) begin
      push_rx({msk, wsfd_pkg::LEN_ESC16});
      push_rx(len64[15:8]);
      push_rx(len64[7:0]);
    end else begin
      push_rx({msk, wsfd_pkg::LEN_ESC64});
      for (int i = 7; i >= 0; i--) push_rx(len64[8*i +: 8]);
    end
    if (msk) repeat (4) push_rx(8'($urandom_range(255)));
    repeat (len) push_rx(8'($urandom_range(255)));
  endtask

  task automatic queue_message();
    int unsigned pick;
    int unsigned nfrag;
    logic [3:0]  op;
    pick = $urandom_range(99);
    if (pick < 55) begin
      op = (pick < 38) ? wsfd_pkg::OP_TEXT : wsfd_pkg::OP_BINARY;
      nfrag = ($urandom_range(2) == 0) ? $urandom_range(4, 2) : 1;
      for (int f = 0; f < nfrag; f++) begin
        queue_frame(f == nfrag - 1, (f == 0) ? op : wsfd_pkg::OP_CONT, 1'b0,
                    pick_len());
        if (f != nfrag - 1 && $urandom_range(4) == 0)
          queue_frame(1'b1, wsfd_pkg::OP_PING, 1'b0, $urandom_range(4));
      end
    end else if (pick < 65) begin
      queue_frame(1'b1, wsfd_pkg::OP_CLOSE, 1'b0, $urandom_range(6));
    end else if (pick < 73) begin
      queue_frame(1'b1, wsfd_pkg::OP_PING, 1'b0, $urandom_range(8));
    end else if (pick < 78) begin
      queue_frame(1'b1, OP_PONG, 1'b0, $urandom_range(5));
    end else if (pick < 88) begin
      queue_frame(1'($urandom_range(1)), 4'($urandom_range(15)), 1'b1, pick_len());
    end else begin
      // noise: any opcode, any final bit, sometimes masked
      queue_frame(1'($urandom_range(1)), 4'($urandom_range(15)),
                  $urandom_range(3) == 0, $urandom_range(10));
    end
  endtask

  task automatic queue_traffic(input int unsigned nbytes);
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < nbytes) queue_message();
  endtask

  task automatic wait_quiet();
    while (rx_stream.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_events.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || rx_taken) begin
      if (rx_stream.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_valid_i <= 1'b1;
        rx_byte_i <= rx_stream.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_ask != hold_served) begin
      hold_served = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    wsfd_pkg::result_t want;
    rx_taken = in_valid_i && !in_stall_o;
    if (rx_taken) parse_rx_byte(rx_byte_i);
    if (out_valid_o && !out_stall_i) begin
      if (due_events.size() == 0) begin
        $error("event_kind: expected no transaction, got %0d", event_kind_o);
        mismatches++;
      end else begin
        want = due_events.pop_front();
        check_field("event_kind", 16'(want.kind), 16'(event_kind_o));
        check_field("data_byte", 16'(want.data), 16'(data_byte_o));
        check_field("has_byte", 16'(want.has_byte), 16'(has_byte_o));
        check_field("end_of_message", 16'(want.eom), 16'(end_of_message_o));
        check_field("close_code", want.code, close_code_o);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = OPENING_LEN - 1; i >= 0; i--) push_rx(OPENING[8*i +: 8]);

    // Long receiver hold-off against a steady text stream: the block fills
    // and must stall its input.
    hold_ask++;
    queue_frame(1'b1, wsfd_pkg::OP_TEXT, 1'b0, 120);
    queue_traffic(100);
    // Sender pauses until every pending event has come out
    wait_quiet();

    src_idle_pct = 88;
    queue_traffic(225);
    wait_quiet();

    src_idle_pct = 0;
    sink_stall_pct = 88;
    queue_traffic(225);
    wait_quiet();

    src_idle_pct = 17;
    sink_stall_pct = 17;
    queue_traffic(225);
    // Text frame with a huge 64-bit length: the parser stays in payload to
    // the end, so it goes last.
    push_rx({1'b1, 3'b000, wsfd_pkg::OP_TEXT});
    push_rx({1'b0, wsfd_pkg::LEN_ESC64});
    push_rx(8'h80 | 8'($urandom_range(127)));
    repeat (7) push_rx(8'($urandom_range(255)));
    repeat (30) push_rx(8'($urandom_range(255)));
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
